@@ rtl/uvp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvp_pkg
// Shared types, event codes and the DEC special-graphics table for the
// terminal byte parser.
// ----------------------------------------------------------------------------
package uvp_pkg;

  localparam int PARAM_MAX_DEFAULT        = 16;
  localparam int ESC_BUFFER_BYTES_DEFAULT = 64;
  localparam int PARAM_MAX_HIGH           = 32;
  localparam int TOTAL_W                  = $clog2(PARAM_MAX_HIGH + 1);
  localparam int ADDR_W                   = $clog2(PARAM_MAX_HIGH);
  localparam int QUEUE_DEPTH              = 4;

  localparam logic [3:0] KIND_PRINT    = 4'd0;
  localparam logic [3:0] KIND_CR       = 4'd1;
  localparam logic [3:0] KIND_LF       = 4'd2;
  localparam logic [3:0] KIND_BS       = 4'd3;
  localparam logic [3:0] KIND_TAB      = 4'd4;
  localparam logic [3:0] KIND_REVINDEX = 4'd5;
  localparam logic [3:0] KIND_SAVE     = 4'd6;
  localparam logic [3:0] KIND_RESTORE  = 4'd7;
  localparam logic [3:0] KIND_RESET    = 4'd8;
  localparam logic [3:0] KIND_PARAM    = 4'd9;
  localparam logic [3:0] KIND_DISPATCH = 4'd10;

  // one request from the front to the back
  typedef struct packed {
    logic [3:0]         kind;
    logic [20:0]        code_point;
    logic [TOTAL_W-1:0] total;
    logic               private_mark;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } store_wr_t;

  function automatic logic [20:0] dec_graphics(input logic [4:0] idx);
    logic [20:0] r;
    case (idx)
      5'd0:  r = 21'h25C6;
      5'd1:  r = 21'h2592;
      5'd2:  r = 21'h2409;
      5'd3:  r = 21'h240C;
      5'd4:  r = 21'h240D;
      5'd5:  r = 21'h240A;
      5'd6:  r = 21'h00B0;
      5'd7:  r = 21'h00B1;
      5'd8:  r = 21'h2424;
      5'd9:  r = 21'h240B;
      5'd10: r = 21'h2518;
      5'd11: r = 21'h2510;
      5'd12: r = 21'h250C;
      5'd13: r = 21'h2514;
      5'd14: r = 21'h253C;
      5'd15: r = 21'h23BA;
      5'd16: r = 21'h23BB;
      5'd17: r = 21'h2500;
      5'd18: r = 21'h23BC;
      5'd19: r = 21'h23BD;
      5'd20: r = 21'h251C;
      5'd21: r = 21'h2524;
      5'd22: r = 21'h2534;
      5'd23: r = 21'h252C;
      5'd24: r = 21'h2502;
      5'd25: r = 21'h2264;
      5'd26: r = 21'h2265;
      5'd27: r = 21'h03C0;
      5'd28: r = 21'h2260;
      5'd29: r = 21'h00A3;
      5'd30: r = 21'h00B7;
      default: r = 21'h0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/uvp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvp_front
// UTF-8 decoder and escape state machine. Takes one byte per request and
// pushes at most one event request into the queue.
// ----------------------------------------------------------------------------
module uvp_front #(
  parameter int PARAM_MAX        = uvp_pkg::PARAM_MAX_DEFAULT,
  parameter int ESC_BUFFER_BYTES = uvp_pkg::ESC_BUFFER_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_stall,
  input  logic [7:0]         data_byte,
  input  logic               queue_full,
  input  logic               dispatch_busy,
  output logic               push,
  output uvp_pkg::cmd_t      cmd,
  output uvp_pkg::store_wr_t store_wr
);

  localparam int TW = $clog2(PARAM_MAX + 1);
  localparam int CW = $clog2(ESC_BUFFER_BYTES);
  localparam logic [TW-1:0] PMAX  = TW'(PARAM_MAX);
  localparam logic [CW-1:0] LIMIT = CW'(ESC_BUFFER_BYTES - 1);

  localparam logic [2:0] ST_TEXT    = 3'd0;
  localparam logic [2:0] ST_ESCAPE  = 3'd1;
  localparam logic [2:0] ST_CHARSET = 3'd2;
  localparam logic [2:0] ST_CSI     = 3'd3;
  localparam logic [2:0] ST_OSC     = 3'd4;

  localparam logic [20:0] CH_BEL       = 21'h07;
  localparam logic [20:0] CH_BS        = 21'h08;
  localparam logic [20:0] CH_TAB       = 21'h09;
  localparam logic [20:0] CH_LF        = 21'h0A;
  localparam logic [20:0] CH_VT        = 21'h0B;
  localparam logic [20:0] CH_FF        = 21'h0C;
  localparam logic [20:0] CH_CR        = 21'h0D;
  localparam logic [20:0] CH_ESC       = 21'h1B;
  localparam logic [20:0] CH_SPACE     = 21'h20;
  localparam logic [20:0] CH_G0        = 21'h28;
  localparam logic [20:0] CH_G1        = 21'h29;
  localparam logic [20:0] CH_ZERO      = 21'h30;
  localparam logic [20:0] CH_SAVE      = 21'h37;
  localparam logic [20:0] CH_RESTORE   = 21'h38;
  localparam logic [20:0] CH_NINE      = 21'h39;
  localparam logic [20:0] CH_SEMI      = 21'h3B;
  localparam logic [20:0] CH_QUERY     = 21'h3F;
  localparam logic [20:0] CH_FINAL_LO  = 21'h40;
  localparam logic [20:0] CH_REVINDEX  = 21'h4D;
  localparam logic [20:0] CH_CSI_OPEN  = 21'h5B;
  localparam logic [20:0] CH_BACKSLASH = 21'h5C;
  localparam logic [20:0] CH_OSC_OPEN  = 21'h5D;
  localparam logic [20:0] CH_GFX_LO    = 21'h60;
  localparam logic [20:0] CH_RIS       = 21'h63;
  localparam logic [20:0] CH_FINAL_HI  = 21'h7E;

  logic [20:0]   utf8_accum, utf8_accum_next;
  logic [1:0]    utf8_remaining, utf8_remaining_next;
  logic [2:0]    parse_state, parse_state_next;
  logic          osc_escape_seen, osc_escape_seen_next;
  logic          graphics_charset, graphics_charset_next;
  logic [CW-1:0] stored_byte_count, stored_byte_count_next;
  logic [TW-1:0] param_total, param_total_next;
  logic [15:0]   digit_accum, digit_accum_next;
  logic          digit_seen, digit_seen_next;
  logic          private_flag, private_flag_next;

  logic          accept;
  logic          char_ready;
  logic [20:0]   ch;
  logic [19:0]   prod;
  logic [TW-1:0] total_closed;

  assign data_stall = queue_full || (parse_state == ST_CSI && dispatch_busy);
  assign accept     = data_valid && !data_stall;
  assign prod       = 20'(digit_accum) * 20'd10 + 20'(ch[3:0]);
  assign total_closed = (param_total < PMAX) ? param_total + TW'(1) : param_total;

  always_comb begin
    utf8_accum_next        = utf8_accum;
    utf8_remaining_next    = utf8_remaining;
    parse_state_next       = parse_state;
    osc_escape_seen_next   = osc_escape_seen;
    graphics_charset_next  = graphics_charset;
    stored_byte_count_next = stored_byte_count;
    param_total_next       = param_total;
    digit_accum_next       = digit_accum;
    digit_seen_next        = digit_seen;
    private_flag_next      = private_flag;
    push                   = 1'b0;
    cmd                    = '0;
    store_wr               = '0;
    store_wr.addr          = uvp_pkg::ADDR_W'(param_total);
    store_wr.data          = digit_accum;
    char_ready             = 1'b0;
    ch                     = 21'(data_byte);

    if (utf8_remaining != 2'd0 && data_byte[7:6] == 2'b10) begin
      utf8_accum_next     = {utf8_accum[14:0], data_byte[5:0]};
      utf8_remaining_next = utf8_remaining - 2'd1;
      char_ready          = (utf8_remaining == 2'd1);
      ch                  = utf8_accum_next;
    end else if (data_byte >= 8'hC0) begin
      if (data_byte < 8'hE0) begin
        utf8_accum_next     = 21'(data_byte & 8'h1F);
        utf8_remaining_next = 2'd1;
      end else if (data_byte < 8'hF0) begin
        utf8_accum_next     = 21'(data_byte & 8'h0F);
        utf8_remaining_next = 2'd2;
      end else begin
        utf8_accum_next     = 21'(data_byte & 8'h07);
        utf8_remaining_next = 2'd3;
      end
    end else begin
      utf8_accum_next     = 21'(data_byte);
      utf8_remaining_next = 2'd0;
      char_ready          = 1'b1;
    end

    if (char_ready) begin
      case (parse_state)
        ST_ESCAPE: begin
          parse_state_next = ST_TEXT;
          if (ch == CH_CSI_OPEN) begin
            parse_state_next       = ST_CSI;
            stored_byte_count_next = '0;
            param_total_next       = '0;
            digit_accum_next       = '0;
            digit_seen_next        = 1'b0;
            private_flag_next      = 1'b0;
          end else if (ch inside {CH_G0, CH_G1}) begin
            parse_state_next = ST_CHARSET;
          end else if (ch == CH_OSC_OPEN) begin
            parse_state_next     = ST_OSC;
            osc_escape_seen_next = 1'b0;
          end else if (ch == CH_REVINDEX) begin
            push     = 1'b1;
            cmd.kind = uvp_pkg::KIND_REVINDEX;
          end else if (ch == CH_SAVE) begin
            push     = 1'b1;
            cmd.kind = uvp_pkg::KIND_SAVE;
          end else if (ch == CH_RESTORE) begin
            push     = 1'b1;
            cmd.kind = uvp_pkg::KIND_RESTORE;
          end else if (ch == CH_RIS) begin
            graphics_charset_next = 1'b0;
            push                  = 1'b1;
            cmd.kind              = uvp_pkg::KIND_RESET;
          end
        end
        ST_CHARSET: begin
          graphics_charset_next = (ch == CH_ZERO);
          parse_state_next      = ST_TEXT;
        end
        ST_CSI: begin
          if (ch == CH_QUERY) begin
            private_flag_next = 1'b1;
          end else if (ch inside {[CH_FINAL_LO:CH_FINAL_HI]}) begin
            push             = 1'b1;
            cmd.kind         = uvp_pkg::KIND_DISPATCH;
            cmd.code_point   = ch;
            cmd.private_mark = private_flag;
            cmd.total        = uvp_pkg::TOTAL_W'(param_total);
            if (digit_seen) begin
              store_wr.en      = (param_total < PMAX);
              param_total_next = total_closed;
              cmd.total        = uvp_pkg::TOTAL_W'(total_closed);
              digit_accum_next = '0;
              digit_seen_next  = 1'b0;
            end
            parse_state_next = ST_TEXT;
          end else if (stored_byte_count < LIMIT) begin
            stored_byte_count_next = stored_byte_count + CW'(1);
            if (ch inside {[CH_ZERO:CH_NINE]}) begin
              digit_accum_next = (prod > 20'hFFFF) ? 16'hFFFF : prod[15:0];
              digit_seen_next  = 1'b1;
            end else if (ch == CH_SEMI) begin
              store_wr.en      = (param_total < PMAX);
              param_total_next = total_closed;
              digit_accum_next = '0;
              digit_seen_next  = 1'b0;
            end
          end
        end
        ST_OSC: begin
          if (ch == CH_BEL || (ch == CH_BACKSLASH && osc_escape_seen)) begin
            parse_state_next     = ST_TEXT;
            osc_escape_seen_next = 1'b0;
          end else begin
            osc_escape_seen_next = (ch == CH_ESC);
          end
        end
        default: begin
          parse_state_next = ST_TEXT;
          if (ch == CH_ESC) begin
            parse_state_next       = ST_ESCAPE;
            stored_byte_count_next = '0;
          end else if (ch == CH_CR) begin
            push     = 1'b1;
            cmd.kind = uvp_pkg::KIND_CR;
          end else if (ch inside {CH_LF, CH_VT, CH_FF}) begin
            push     = 1'b1;
            cmd.kind = uvp_pkg::KIND_LF;
          end else if (ch == CH_BS) begin
            push     = 1'b1;
            cmd.kind = uvp_pkg::KIND_BS;
          end else if (ch == CH_TAB) begin
            push     = 1'b1;
            cmd.kind = uvp_pkg::KIND_TAB;
          end else if (ch >= CH_SPACE) begin
            push     = 1'b1;
            cmd.kind = uvp_pkg::KIND_PRINT;
            if (graphics_charset && (ch inside {[CH_GFX_LO:CH_FINAL_HI]})) begin
              cmd.code_point = uvp_pkg::dec_graphics(5'(ch - CH_GFX_LO));
            end else begin
              cmd.code_point = ch;
            end
          end
        end
      endcase
    end

    if (!accept) begin
      push        = 1'b0;
      store_wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_accum        <= '0;
      utf8_remaining    <= '0;
      parse_state       <= ST_TEXT;
      osc_escape_seen   <= 1'b0;
      graphics_charset  <= 1'b0;
      stored_byte_count <= '0;
      param_total       <= '0;
      digit_accum       <= '0;
      digit_seen        <= 1'b0;
      private_flag      <= 1'b0;
    end else if (accept) begin
      utf8_accum        <= utf8_accum_next;
      utf8_remaining    <= utf8_remaining_next;
      parse_state       <= parse_state_next;
      osc_escape_seen   <= osc_escape_seen_next;
      graphics_charset  <= graphics_charset_next;
      stored_byte_count <= stored_byte_count_next;
      param_total       <= param_total_next;
      digit_accum       <= digit_accum_next;
      digit_seen        <= digit_seen_next;
      private_flag      <= private_flag_next;
    end
  end

endmodule

@@ rtl/uvp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvp_queue
// Short request queue between front and back; flags a pending dispatch so
// the front holds off parameter store writes.
// ----------------------------------------------------------------------------
module uvp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uvp_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          head_valid,
  output uvp_pkg::cmd_t head,
  output logic          full,
  output logic          dispatch_busy
);

  localparam int DEPTH = uvp_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  uvp_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [PW:0]   count;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign full       = (count == (PW+1)'(DEPTH));

  always_comb begin
    logic [PW-1:0] off;
    dispatch_busy = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      off = PW'(i) - rd_ptr;
      if ((PW+1)'(off) < count && entries[i].kind == uvp_pkg::KIND_DISPATCH) begin
        dispatch_busy = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/uvp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvp_back
// Holds the CSI parameter store and turns each queued request into result
// items, one per unstalled cycle, through the output register.
// ----------------------------------------------------------------------------
module uvp_back #(
  parameter int PARAM_MAX = uvp_pkg::PARAM_MAX_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  uvp_pkg::store_wr_t store_wr,
  input  logic               head_valid,
  input  uvp_pkg::cmd_t      head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [3:0]         kind,
  output logic [20:0]        code_point,
  output logic [15:0]        param_value,
  output logic [3:0]         param_index,
  output logic [4:0]         param_count,
  output logic               private_mark,
  output logic               last_of_run
);

  localparam int TW    = $clog2(PARAM_MAX + 1);
  localparam int IDX_W = (PARAM_MAX > 1) ? $clog2(PARAM_MAX) : 1;

  logic [15:0]   param_store [PARAM_MAX];
  logic [TW-1:0] idx;
  logic          load;
  logic          in_params;

  assign load      = head_valid && (!result_valid || !result_stall);
  assign in_params = (head.kind == uvp_pkg::KIND_DISPATCH) && (TW'(head.total) > idx);
  assign pop       = load && !in_params;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      param_store[store_wr.addr[IDX_W-1:0]] <= store_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      if (!result_valid || !result_stall) begin
        result_valid <= head_valid;
      end
      if (load) begin
        idx <= in_params ? idx + TW'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      param_count  <= head.total[4:0];
      private_mark <= head.private_mark;
      if (in_params) begin
        kind        <= uvp_pkg::KIND_PARAM;
        code_point  <= '0;
        param_value <= param_store[idx[IDX_W-1:0]];
        param_index <= 4'(idx);
        last_of_run <= 1'b0;
      end else begin
        kind        <= head.kind;
        code_point  <= head.code_point;
        param_value <= '0;
        param_index <= '0;
        last_of_run <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/utf8_vt100_escape_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_vt100_escape_parser
// Terminal byte parser: UTF-8 decode, VT100 escape state machine and CSI
// parameter expansion.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while data_stall is low and gives at most one
// result per cycle. A byte that decodes to a print or control event goes
// through a queue entry and then the result register. A CSI final byte
// expands into one parameter result per stored parameter and then the
// dispatch result, one per cycle while result_stall is low. While such a
// dispatch is still queued or expanding, bytes inside a following CSI
// sequence are held off, since the back end reads the shared parameter
// store; bytes outside a CSI flow on through a four-entry queue.
module utf8_vt100_escape_parser #(
  parameter int PARAM_MAX        = uvp_pkg::PARAM_MAX_DEFAULT,
  parameter int ESC_BUFFER_BYTES = uvp_pkg::ESC_BUFFER_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  kind,
  output logic [20:0] code_point,
  output logic [15:0] param_value,
  output logic [3:0]  param_index,
  output logic [4:0]  param_count,
  output logic        private_mark,
  output logic        last_of_run
);

  logic               push;
  uvp_pkg::cmd_t      push_cmd;
  uvp_pkg::store_wr_t store_wr;
  logic               pop;
  logic               head_valid;
  uvp_pkg::cmd_t      head;
  logic               full;
  logic               dispatch_busy;

  uvp_front #(
    .PARAM_MAX        (PARAM_MAX),
    .ESC_BUFFER_BYTES (ESC_BUFFER_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_byte     (data_byte),
    .queue_full    (full),
    .dispatch_busy (dispatch_busy),
    .push          (push),
    .cmd           (push_cmd),
    .store_wr      (store_wr)
  );

  uvp_queue u_queue (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_cmd      (push_cmd),
    .pop           (pop),
    .head_valid    (head_valid),
    .head          (head),
    .full          (full),
    .dispatch_busy (dispatch_busy)
  );

  uvp_back #(
    .PARAM_MAX (PARAM_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .store_wr     (store_wr),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .code_point   (code_point),
    .param_value  (param_value),
    .param_index  (param_index),
    .param_count  (param_count),
    .private_mark (private_mark),
    .last_of_run  (last_of_run)
  );

endmodule

@@ tb/tb_utf8_vt100_escape_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_vt100_escape_parser
// Self-checking bench for the terminal byte parser. Byte requests go in on a
// valid/stall channel and event requests come out on another. A scoreboard
// object tracks UTF-8 decoding, the escape state machine and CSI parameter
// collection, queues the events each accepted byte should cause and checks
// every accepted event against the oldest one. A short directed run is
// followed by random terminal traffic, mostly well-formed escape, CSI, OSC
// and UTF-8 sequences with some noise, under random idling on both sides
// and one long hold-off on the event side.
// ----------------------------------------------------------------------------
module tb_utf8_vt100_escape_parser;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 2;
  localparam int PARAM_LIMIT    = uvp_pkg::PARAM_MAX_DEFAULT;
  localparam int BUF_LIMIT      = uvp_pkg::ESC_BUFFER_BYTES_DEFAULT;
  localparam int RANDOM_ITEMS   = 100;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PARAM_SAT      = 65535;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_VT        = 8'h0B;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_CTRL_HI   = 8'h1F;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_G0        = 8'h28;
  localparam logic [7:0] CH_G1        = 8'h29;
  localparam logic [7:0] CH_INTER_HI  = 8'h2F;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_SAVE      = 8'h37;
  localparam logic [7:0] CH_RESTORE   = 8'h38;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_QUERY     = 8'h3F;
  localparam logic [7:0] CH_FINAL_LO  = 8'h40;
  localparam logic [7:0] CH_REVINDEX  = 8'h4D;
  localparam logic [7:0] CH_CSI_OPEN  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_OSC_OPEN  = 8'h5D;
  localparam logic [7:0] CH_GFX_LO    = 8'h60;
  localparam logic [7:0] CH_RIS       = 8'h63;
  localparam logic [7:0] CH_FINAL_HI  = 8'h7E;
  localparam logic [7:0] CH_DEL       = 8'h7F;
  localparam logic [7:0] UTF8_CONT_LO = 8'h80;
  localparam logic [7:0] UTF8_CONT_HI = 8'hBF;
  localparam logic [7:0] UTF8_LEAD4   = 8'hF0;
  localparam logic [7:0] BYTE_MAX     = 8'hFF;

  localparam int TOK_PRINT_A   = 0;
  localparam int TOK_PRINT_B   = 1;
  localparam int TOK_CONTROL   = 2;
  localparam int TOK_ANY       = 3;
  localparam int TOK_UTF8_A    = 4;
  localparam int TOK_UTF8_B    = 5;
  localparam int TOK_UTF8_BAD  = 6;
  localparam int TOK_ESC       = 7;
  localparam int TOK_CHARSET   = 8;
  localparam int TOK_CSI_A     = 9;
  localparam int TOK_CSI_B     = 10;
  localparam int TOK_CSI_C     = 11;
  localparam int TOK_OSC       = 12;
  localparam int TOK_CSI_MANY  = 13;
  localparam int TOK_CSI_LONG  = 14;

  typedef enum logic [2:0] {
    PS_GROUND  = 3'd0,
    PS_ESCAPE  = 3'd1,
    PS_CHARSET = 3'd2,
    PS_CSI     = 3'd3,
    PS_OSC     = 3'd4
  } parse_state_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [20:0] code_point;
    logic [15:0] param_value;
    logic [3:0]  param_index;
    logic [4:0]  param_count;
    logic        private_mark;
    logic        last_of_run;
  } term_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [3:0]  kind;
  logic [20:0] code_point;
  logic [15:0] param_value;
  logic [3:0]  param_index;
  logic [4:0]  param_count;
  logic        private_mark;
  logic        last_of_run;

  bit hold_req  = 1'b0;
  bit hold_busy = 1'b0;
  bit no_idle   = 1'b0;
  int sent_count = 0;
  int idle_cycles = 0;

  class parse_scoreboard;
    term_event_t  want_q[$];
    int           errors;
    logic [20:0]  utf8_acc;
    logic [1:0]   utf8_left;
    parse_state_e pstate;
    bit           osc_esc;
    bit           gfx;
    int unsigned  byte_cnt;
    logic [15:0]  param_vals[PARAM_LIMIT];
    int unsigned  param_num;
    int unsigned  digit_acc;
    bit           digit_any;
    bit           priv;

    function new();
      errors    = 0;
      utf8_acc  = '0;
      utf8_left = '0;
      pstate    = PS_GROUND;
      osc_esc   = 1'b0;
      gfx       = 1'b0;
      byte_cnt  = 0;
      param_num = 0;
      digit_acc = 0;
      digit_any = 1'b0;
      priv      = 1'b0;
      foreach (param_vals[i]) param_vals[i] = '0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function logic [20:0] gfx_glyph(int idx);
      logic [20:0] g;
      case (idx)
        0:  g = 21'h25C6;
        1:  g = 21'h2592;
        2:  g = 21'h2409;
        3:  g = 21'h240C;
        4:  g = 21'h240D;
        5:  g = 21'h240A;
        6:  g = 21'h00B0;
        7:  g = 21'h00B1;
        8:  g = 21'h2424;
        9:  g = 21'h240B;
        10: g = 21'h2518;
        11: g = 21'h2510;
        12: g = 21'h250C;
        13: g = 21'h2514;
        14: g = 21'h253C;
        15: g = 21'h23BA;
        16: g = 21'h23BB;
        17: g = 21'h2500;
        18: g = 21'h23BC;
        19: g = 21'h23BD;
        20: g = 21'h251C;
        21: g = 21'h2524;
        22: g = 21'h2534;
        23: g = 21'h252C;
        24: g = 21'h2502;
        25: g = 21'h2264;
        26: g = 21'h2265;
        27: g = 21'h03C0;
        28: g = 21'h2260;
        29: g = 21'h00A3;
        default: g = 21'h00B7;
      endcase
      return g;
    endfunction

    function term_event_t make_event(logic [3:0] k, logic [20:0] cp, logic [15:0] val,
                                     logic [3:0] idx, logic [4:0] cnt, logic pm);
      term_event_t e;
      e.kind         = k;
      e.code_point   = cp;
      e.param_value  = val;
      e.param_index  = idx;
      e.param_count  = cnt;
      e.private_mark = pm;
      e.last_of_run  = 1'b0;
      return e;
    endfunction

    function void close_param();
      if (param_num < PARAM_LIMIT) begin
        param_vals[param_num] = digit_acc[15:0];
        param_num++;
      end
      digit_acc = 0;
      digit_any = 1'b0;
    endfunction

    // one accepted byte: advance the model and queue the events it causes
    function void note_byte(logic [7:0] b);
      term_event_t evs[$];
      logic [20:0] ch;
      logic [20:0] glyph;
      int unsigned v;
      if (utf8_left != 0 && b[7:6] == 2'b10) begin
        utf8_acc = {utf8_acc[14:0], b[5:0]};
        utf8_left--;
        if (utf8_left != 0) return;
      end else if (b[7:6] == 2'b11) begin
        if (!b[5]) begin
          utf8_acc  = {16'd0, b[4:0]};
          utf8_left = 2'd1;
        end else if (!b[4]) begin
          utf8_acc  = {17'd0, b[3:0]};
          utf8_left = 2'd2;
        end else begin
          utf8_acc  = {18'd0, b[2:0]};
          utf8_left = 2'd3;
        end
        return;
      end else begin
        utf8_acc  = {13'd0, b};
        utf8_left = 2'd0;
      end
      ch = utf8_acc;

      case (pstate)
        PS_ESCAPE: begin
          pstate = PS_GROUND;
          if (ch == CH_CSI_OPEN) begin
            pstate    = PS_CSI;
            byte_cnt  = 0;
            param_num = 0;
            digit_acc = 0;
            digit_any = 1'b0;
            priv      = 1'b0;
          end else if (ch inside {CH_G0, CH_G1}) begin
            pstate = PS_CHARSET;
          end else if (ch == CH_OSC_OPEN) begin
            pstate  = PS_OSC;
            osc_esc = 1'b0;
          end else if (ch == CH_REVINDEX) begin
            evs.push_back(make_event(uvp_pkg::KIND_REVINDEX, '0, '0, '0, '0, 1'b0));
          end else if (ch == CH_SAVE) begin
            evs.push_back(make_event(uvp_pkg::KIND_SAVE, '0, '0, '0, '0, 1'b0));
          end else if (ch == CH_RESTORE) begin
            evs.push_back(make_event(uvp_pkg::KIND_RESTORE, '0, '0, '0, '0, 1'b0));
          end else if (ch == CH_RIS) begin
            gfx = 1'b0;
            evs.push_back(make_event(uvp_pkg::KIND_RESET, '0, '0, '0, '0, 1'b0));
          end
        end
        PS_CHARSET: begin
          gfx    = (ch == CH_ZERO);
          pstate = PS_GROUND;
        end
        PS_CSI: begin
          if (ch == CH_QUERY) begin
            priv = 1'b1;
          end else if (ch inside {[CH_FINAL_LO:CH_FINAL_HI]}) begin
            if (digit_any) close_param();
            for (int i = 0; i < param_num; i++)
              evs.push_back(make_event(uvp_pkg::KIND_PARAM, '0, param_vals[i], 4'(i),
                                       5'(param_num), priv));
            evs.push_back(make_event(uvp_pkg::KIND_DISPATCH, ch, '0, '0,
                                     5'(param_num), priv));
            pstate = PS_GROUND;
          end else if (byte_cnt < BUF_LIMIT - 1) begin
            byte_cnt++;
            if (ch inside {[CH_ZERO:CH_NINE]}) begin
              v = digit_acc * 10 + int'(ch) - int'(CH_ZERO);
              digit_acc = (v > PARAM_SAT) ? PARAM_SAT : v;
              digit_any = 1'b1;
            end else if (ch == CH_SEMI) begin
              close_param();
            end
          end
        end
        PS_OSC: begin
          if (ch == CH_BEL || (ch == CH_BACKSLASH && osc_esc)) begin
            pstate  = PS_GROUND;
            osc_esc = 1'b0;
          end else begin
            osc_esc = (ch == CH_ESC);
          end
        end
        default: begin
          pstate = PS_GROUND;
          if (ch == CH_ESC) begin
            pstate   = PS_ESCAPE;
            byte_cnt = 0;
          end else if (ch == CH_CR) begin
            evs.push_back(make_event(uvp_pkg::KIND_CR, '0, '0, '0, '0, 1'b0));
          end else if (ch inside {CH_LF, CH_VT, CH_FF}) begin
            evs.push_back(make_event(uvp_pkg::KIND_LF, '0, '0, '0, '0, 1'b0));
          end else if (ch == CH_BS) begin
            evs.push_back(make_event(uvp_pkg::KIND_BS, '0, '0, '0, '0, 1'b0));
          end else if (ch == CH_TAB) begin
            evs.push_back(make_event(uvp_pkg::KIND_TAB, '0, '0, '0, '0, 1'b0));
          end else if (ch >= CH_SPACE) begin
            glyph = ch;
            if (gfx && (ch inside {[CH_GFX_LO:CH_FINAL_HI]}))
              glyph = gfx_glyph(int'(ch) - int'(CH_GFX_LO));
            evs.push_back(make_event(uvp_pkg::KIND_PRINT, glyph, '0, '0, '0, 1'b0));
          end
        end
      endcase

      if (evs.size() > 0) evs[evs.size()-1].last_of_run = 1'b1;
      foreach (evs[i]) want_q.push_back(evs[i]);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(term_event_t got);
      term_event_t exp;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected event kind %0d", got.kind));
        return;
      end
      exp = want_q.pop_front();
      if (got.kind !== exp.kind)
        report($sformatf("kind got %0d exp %0d", got.kind, exp.kind));
      if (got.code_point !== exp.code_point)
        report($sformatf("code_point got %h exp %h", got.code_point, exp.code_point));
      if (got.param_value !== exp.param_value)
        report($sformatf("param_value got %0d exp %0d", got.param_value, exp.param_value));
      if (got.param_index !== exp.param_index)
        report($sformatf("param_index got %0d exp %0d", got.param_index, exp.param_index));
      if (got.param_count !== exp.param_count)
        report($sformatf("param_count got %0d exp %0d", got.param_count, exp.param_count));
      if (got.private_mark !== exp.private_mark)
        report($sformatf("private_mark got %b exp %b", got.private_mark, exp.private_mark));
      if (got.last_of_run !== exp.last_of_run)
        report($sformatf("last_of_run got %b exp %b", got.last_of_run, exp.last_of_run));
    endtask
  endclass

  parse_scoreboard sb;

  utf8_vt100_escape_parser #(
    .PARAM_MAX        (PARAM_LIMIT),
    .ESC_BUFFER_BYTES (BUF_LIMIT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .code_point   (code_point),
    .param_value  (param_value),
    .param_index  (param_index),
    .param_count  (param_count),
    .private_mark (private_mark),
    .last_of_run  (last_of_run)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int draw_gap();
    return (no_idle || hold_busy) ? 0 : $urandom_range(0, 15);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (data_stall) @(posedge clk);
    sb.note_byte(b);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic random_token(input int pick);
    logic [7:0] q[$];
    int n, d, k;
    q.delete();
    case (pick)
      TOK_PRINT_A, TOK_PRINT_B: q.push_back(8'($urandom_range(CH_SPACE, CH_DEL)));
      TOK_CONTROL: q.push_back(8'($urandom_range(CH_NUL, CH_CTRL_HI)));
      TOK_ANY: q.push_back(8'($urandom_range(0, BYTE_MAX)));
      TOK_UTF8_A, TOK_UTF8_B: begin
        n = $urandom_range(2, 4);
        case (n)
          2: q.push_back({3'b110, 5'($urandom)});
          3: q.push_back({4'b1110, 4'($urandom)});
          default: q.push_back({4'b1111, 4'($urandom)});
        endcase
        repeat (n - 1) q.push_back({2'b10, 6'($urandom)});
      end
      TOK_UTF8_BAD: begin
        if ($urandom_range(0, 2) == 0) begin
          q.push_back({2'b10, 6'($urandom)});
        end else begin
          n = $urandom_range(2, 4);
          q.push_back({2'b11, 6'($urandom)});
          k = $urandom_range(0, n - 2);
          repeat (k) q.push_back({2'b10, 6'($urandom)});
          if ($urandom_range(0, 1) == 0)
            q.push_back(8'($urandom_range(CH_NUL, CH_DEL)));
          else
            q.push_back({2'b11, 6'($urandom)});
        end
      end
      TOK_ESC: begin
        q.push_back(CH_ESC);
        case ($urandom_range(0, 5))
          0: q.push_back(CH_REVINDEX);
          1: q.push_back(CH_SAVE);
          2: q.push_back(CH_RESTORE);
          3: q.push_back(CH_RIS);
          4: q.push_back(8'($urandom_range(CH_SPACE, CH_FINAL_HI)));
          default: q.push_back(8'($urandom_range(0, BYTE_MAX)));
        endcase
      end
      TOK_CHARSET: begin
        q.push_back(CH_ESC);
        q.push_back($urandom_range(0, 1) ? CH_G1 : CH_G0);
        if ($urandom_range(0, 1) == 0) q.push_back(CH_ZERO);
        else q.push_back(8'($urandom_range(CH_SPACE, CH_FINAL_HI)));
        repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(CH_GFX_LO - 2, CH_DEL)));
      end
      TOK_OSC: begin
        q.push_back(CH_ESC);
        q.push_back(CH_OSC_OPEN);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 7) == 0) q.push_back(CH_ESC);
          q.push_back(8'($urandom_range(CH_SPACE, CH_FINAL_HI)));
        end
        if ($urandom_range(0, 1) == 0) begin
          q.push_back(CH_BEL);
        end else begin
          q.push_back(CH_ESC);
          q.push_back(CH_BACKSLASH);
        end
      end
      TOK_CSI_LONG: begin
        // can run past the buffer limit so later digits are dropped
        q.push_back(CH_ESC);
        q.push_back(CH_CSI_OPEN);
        repeat ($urandom_range(BUF_LIMIT - 6, BUF_LIMIT + 2))
          q.push_back(8'($urandom_range(CH_SPACE, CH_INTER_HI)));
        repeat (2) q.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
        q.push_back(CH_SEMI);
        repeat (2) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        q.push_back(8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
      end
      default: begin
        q.push_back(CH_ESC);
        q.push_back(CH_CSI_OPEN);
        if ($urandom_range(0, 2) == 0) q.push_back(CH_QUERY);
        n = (pick == TOK_CSI_MANY) ? $urandom_range(PARAM_LIMIT + 1, PARAM_LIMIT + 3)
                                   : $urandom_range(0, 4);
        for (k = 0; k < n; k++) begin
          if (k > 0) q.push_back(CH_SEMI);
          if (pick == TOK_CSI_MANY) d = $urandom_range(0, 1);
          else if ($urandom_range(0, 3) == 0) d = $urandom_range(4, 6);
          else d = $urandom_range(0, 2);
          repeat (d) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 0) q.push_back(8'($urandom_range(CH_NUL, CH_INTER_HI)));
            else q.push_back(8'($urandom_range(0, BYTE_MAX)));
          end
        end
        if ($urandom_range(0, 3) == 0) q.push_back(CH_SEMI);
        q.push_back(8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
      end
    endcase
    foreach (q[i]) send_byte(q[i]);
  endtask

  // event side: random stall per request, one long hold-off when asked
  initial begin
    term_event_t got;
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_busy) begin
        hold_busy = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        hold_busy = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      got = {kind, code_point, param_value, param_index, param_count, private_mark,
             last_of_run};
      sb.check_result(got);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_utf8_vt100_escape_parser failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] directed[$];
    int forced[$];
    int tok_num;
    int random_start;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // controls, print extremes, stray and maximal UTF-8, graphics set and reset
    directed = '{CH_NUL, CH_BEL, CH_CR, CH_LF, CH_BS, CH_TAB, CH_SPACE, CH_FINAL_HI,
                 CH_DEL, UTF8_CONT_LO, UTF8_CONT_HI,
                 UTF8_LEAD4 | 8'h07, UTF8_CONT_HI, UTF8_CONT_HI, UTF8_CONT_HI,
                 BYTE_MAX, CH_SPACE,
                 CH_ESC, CH_G0, CH_ZERO, CH_GFX_LO, CH_FINAL_HI, CH_ESC, CH_RIS,
                 CH_GFX_LO};
    foreach (directed[i]) send_byte(directed[i]);

    // every sequence kind once, the long and crowded CSI first
    forced = '{TOK_CSI_LONG, TOK_CSI_MANY, TOK_UTF8_A, TOK_UTF8_BAD, TOK_CHARSET,
               TOK_OSC, TOK_CSI_A, TOK_ESC, TOK_ANY, TOK_CONTROL};

    hold_req = 1'b1;
    tok_num = 0;
    random_start = sent_count;
    while (tok_num < forced.size() || sent_count - random_start < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      random_token(tok_num < forced.size() ? forced[tok_num]
                                           : $urandom_range(TOK_PRINT_A, TOK_OSC));
      tok_num++;
    end
    data_valid <= 1'b0;
    no_idle = 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_utf8_vt100_escape_parser passed");
    else
      $display("tb_utf8_vt100_escape_parser failed");
    $finish;
  end

endmodule
